>>> rtl/core/wrs_pkg.sv
// Shared types and codes for the weighted reward selector.
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int unsigned InIndexBits = 16;
  localparam int unsigned InWeightBits = 16;
  localparam int unsigned ItemBits = 32;
  localparam int unsigned CountBits = 16;
  localparam int unsigned DrawBits = 24;
  localparam int unsigned HeldBits = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RES_ADDED,
    RES_FULL,
    RES_FOUND,
    RES_NO_MATCH,
    RES_REMOVED,
    RES_ABSENT,
    RES_CLEARED
  } res_e;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk;
    logic shift_start;
    logic shift;
    logic shift_end;
    logic add_write;
    logic clear;
    logic finish;
    res_e res;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic neg;
    logic hit;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/wrs_ctrl.sv
// Controller state machine for the weighted reward selector.
`timescale 1ns / 1ps

module wrs_ctrl import wrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] operation_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_CLR   = 6'b000100,
    S_WALK  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (op_e'(operation_i))
            OP_ADD:    state_d = S_ADD;
            OP_CLEAR:  state_d = S_CLR;
            OP_PICK,
            OP_REMOVE: begin
              cmd_o.walk_start = 1'b1;
              state_d = S_WALK;
            end
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts_i.full) begin
          res_d = RES_FULL;
        end else begin
          cmd_o.add_write = 1'b1;
          res_d = RES_ADDED;
        end
        state_d = S_FIN;
      end
      S_CLR: begin
        cmd_o.clear = 1'b1;
        res_d = RES_CLEARED;
        state_d = S_FIN;
      end
      S_WALK: begin
        priority if (sts_i.op == OP_PICK && sts_i.neg) begin
          res_d = RES_NO_MATCH;
          state_d = S_FIN;
        end else if (sts_i.hit) begin
          // hold the hit entry for a pick; start compacting for a remove
          if (sts_i.op == OP_PICK) begin
            res_d = RES_FOUND;
            state_d = S_FIN;
          end else begin
            cmd_o.shift_start = 1'b1;
            state_d = S_SHIFT;
          end
        end else if (sts_i.walk_done) begin
          res_d = (sts_i.op == OP_PICK) ? RES_NO_MATCH : RES_ABSENT;
          state_d = S_FIN;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.walk_done) begin
          cmd_o.shift_end = 1'b1;
          res_d = RES_REMOVED;
          state_d = S_FIN;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_CLEARED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> rtl/core/wrs_datapath.sv
// Entry table, walk pointer, running sum and result register.
`timescale 1ns / 1ps

module wrs_datapath import wrs_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned WEIGHT_BITS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic [1:0]                operation_i,
  input  logic [InWeightBits-1:0]   weight_i,
  input  logic [ItemBits-1:0]       item_id_i,
  input  logic [CountBits-1:0]      item_count_i,
  input  logic [InIndexBits-1:0]    target_index_i,
  input  logic signed [DrawBits-1:0] draw_value_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [1:0]                status_o,
  output logic [InIndexBits-1:0]    chosen_index_o,
  output logic [ItemBits-1:0]       chosen_item_o,
  output logic [CountBits-1:0]      chosen_count_o,
  output logic [HeldBits-1:0]       entries_held_o
);

  localparam int unsigned WB   = (WEIGHT_BITS < InWeightBits) ? WEIGHT_BITS : InWeightBits;
  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SW   = AW + WB;
  localparam int unsigned CMPW = (SW > DrawBits - 1) ? SW : DrawBits - 1;
  localparam int unsigned EW   = InIndexBits + WB + ItemBits + CountBits;
  // word layout: index | weight | item | count
  localparam int unsigned CntLo = 0;
  localparam int unsigned ItmLo = CountBits;
  localparam int unsigned WgtLo = CountBits + ItemBits;
  localparam int unsigned IdxLo = CountBits + ItemBits + WB;

  logic [EW-1:0] mem [TABLE_ENTRIES];

  op_e                     op_q;
  logic [WB-1:0]           weight_q;
  logic [ItemBits-1:0]     item_q;
  logic [CountBits-1:0]    count_q;
  logic [InIndexBits-1:0]  target_q;
  logic [DrawBits-1:0]     draw_q;

  logic [CW-1:0]           fill_q;
  logic [InIndexBits-1:0]  next_idx_q;
  logic [CW-1:0]           ptr_q;
  logic                    rdv_q;
  logic [AW-1:0]           rd_pos_q;
  logic [EW-1:0]           rd_data_q;
  logic [SW-1:0]           sum_q;

  logic                    out_valid_q;
  logic [1:0]              status_q;
  logic [InIndexBits-1:0]  index_q;
  logic [ItemBits-1:0]     oitem_q;
  logic [CountBits-1:0]    ocount_q;
  logic [HeldBits-1:0]     held_q;

  logic [1:0]              status_d;
  logic [InIndexBits-1:0]  index_d;
  logic [ItemBits-1:0]     oitem_d;
  logic [CountBits-1:0]    ocount_d;

  logic                    step, more, issue, we, match;
  logic [AW-1:0]           wr_addr;
  logic [EW-1:0]           wr_data;
  logic [SW-1:0]           sum_plus;
  logic [InIndexBits-1:0]  idx_new;
  logic [InIndexBits-1:0]  rd_idx;
  logic [WB-1:0]           rd_wgt;

  assign rd_idx   = rd_data_q[IdxLo +: InIndexBits];
  assign rd_wgt   = rd_data_q[WgtLo +: WB];
  assign sum_plus = sum_q + SW'(rd_wgt);
  assign idx_new  = (next_idx_q + InIndexBits'(1) == '0) ? InIndexBits'(1)
                                                          : next_idx_q + InIndexBits'(1);

  assign step  = cmd_i.walk || cmd_i.shift;
  assign more  = (ptr_q < fill_q);
  assign issue = step && more;
  assign match = (op_q == OP_PICK) ? (CMPW'(draw_q[DrawBits-2:0]) < CMPW'(sum_plus))
                                   : (rd_idx == target_q);

  assign sts_o.op        = op_q;
  assign sts_o.full      = (fill_q == CW'(TABLE_ENTRIES));
  assign sts_o.neg       = draw_q[DrawBits-1];
  assign sts_o.hit       = rdv_q && match;
  assign sts_o.walk_done = !rdv_q && !more;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // compaction writes the word read last cycle one place lower
  always_comb begin
    we      = 1'b0;
    wr_addr = fill_q[AW-1:0];
    wr_data = {idx_new, weight_q, item_q, count_q};
    if (cmd_i.add_write) begin
      we = 1'b1;
    end else if (cmd_i.shift && rdv_q) begin
      we      = 1'b1;
      wr_addr = rd_pos_q - AW'(1);
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[ptr_q[AW-1:0]];
      rd_pos_q  <= ptr_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(operation_i);
      weight_q <= weight_i[WB-1:0];
      item_q   <= item_id_i;
      count_q  <= item_count_i;
      target_q <= target_index_i;
      draw_q   <= draw_value_i;
    end
    if (cmd_i.walk_start) begin
      sum_q <= '0;
    end else if (cmd_i.walk && rdv_q) begin
      sum_q <= sum_plus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      next_idx_q <= '0;
      ptr_q      <= '0;
      rdv_q      <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        fill_q     <= '0;
        next_idx_q <= '0;
      end else if (cmd_i.add_write) begin
        fill_q     <= fill_q + CW'(1);
        next_idx_q <= idx_new;
      end else if (cmd_i.shift_end) begin
        fill_q     <= fill_q - CW'(1);
      end
      if (cmd_i.walk_start) begin
        ptr_q <= '0;
        rdv_q <= 1'b0;
      end else if (cmd_i.shift_start) begin
        ptr_q <= CW'(rd_pos_q) + CW'(1);
        rdv_q <= 1'b0;
      end else if (step) begin
        ptr_q <= ptr_q + CW'(issue);
        rdv_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_d = ST_DONE;
    index_d  = '0;
    oitem_d  = '0;
    ocount_d = '0;
    unique case (cmd_i.res)
      RES_ADDED: begin
        index_d  = next_idx_q;
        oitem_d  = item_q;
        ocount_d = count_q;
      end
      RES_FULL:     status_d = ST_FULL;
      RES_FOUND: begin
        index_d  = rd_idx;
        oitem_d  = rd_data_q[ItmLo +: ItemBits];
        ocount_d = rd_data_q[CntLo +: CountBits];
      end
      RES_NO_MATCH: status_d = ST_NO_MATCH;
      RES_REMOVED:  index_d  = target_q;
      RES_ABSENT:   status_d = ST_ABSENT;
      RES_CLEARED:  status_d = ST_DONE;
      default:      status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      index_q  <= index_d;
      oitem_q  <= oitem_d;
      ocount_q <= ocount_d;
      held_q   <= HeldBits'(fill_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign chosen_index_o = index_q;
  assign chosen_item_o  = oitem_q;
  assign chosen_count_o = ocount_q;
  assign entries_held_o = held_q;

endmodule

>>> rtl/core/weighted_reward_selector.sv
// Top level of the weighted reward selector: controller plus datapath.
//
//   channel | signals                                     | direction
//   input   | in_valid_i, in_stall_o, operation_i ...     | item in
//   output  | out_valid_o, out_stall_i, status_o ...      | result item out
//
// One item at a time. Add and clear go through their own state and the finish
// state to the output register. Pick and remove grow with the fill: the walk
// reads one table word per cycle through the single registered read port.
// Reset clears the fill count and index counter; the table needs no clearing.
// A held result does not block the next item; it stalls only at the finish.
`timescale 1ns / 1ps

module weighted_reward_selector import wrs_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned WEIGHT_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [InWeightBits-1:0]    weight_i,
  input  logic [ItemBits-1:0]        item_id_i,
  input  logic [CountBits-1:0]       item_count_i,
  input  logic [InIndexBits-1:0]     target_index_i,
  input  logic signed [DrawBits-1:0] draw_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [InIndexBits-1:0]     chosen_index_o,
  output logic [ItemBits-1:0]        chosen_item_o,
  output logic [CountBits-1:0]       chosen_count_o,
  output logic [HeldBits-1:0]        entries_held_o
);

  cmd_t cmd;
  sts_t sts;

  wrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wrs_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .weight_i       (weight_i),
    .item_id_i      (item_id_i),
    .item_count_i   (item_count_i),
    .target_index_i (target_index_i),
    .draw_value_i   (draw_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .chosen_index_o (chosen_index_o),
    .chosen_item_o  (chosen_item_o),
    .chosen_count_o (chosen_count_o),
    .entries_held_o (entries_held_o)
  );

endmodule
